FILE: rtl/all_pairs_shortest_paths_macros.svh
// ----------------------------------------------------------------------------
// All-pairs shortest paths: assertion macros
// Short forms for the concurrent checks, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATHS_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATHS_MACROS_SVH

// Check a property on every rising edge outside reset.
`define APSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define APSP_ASSERT_NEXT(name, pre, post, msg) \
  `APSP_ASSERT(name, (pre) |=> (post), msg)

`endif

FILE: rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// All-pairs shortest paths: package
// Field widths, item kinds, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam int KIND_W     = 3;
  localparam int NODE_W     = 4;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_COMPUTE = 3'd2,
    KIND_DIST    = 3'd3,
    KIND_EDGE    = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 1'b0,
    CFG_DIRECTED   = 1'b1
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic wipe;
    logic add;
    logic mirror;
    logic rd_edge;
    logic rd_dist;
    logic init;
    logic step_j;
    logic row_next;
    logic rd_ik;
    logic ld_ik;
    logic relax;
    logic respond;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              directed;
    logic              wipe_last;
    logic              a_last;
    logic              b_last;
    logic              k_last;
    logic              ik_reach;
    logic              out_free;
  } stat_t;

endpackage

FILE: rtl/apsp_if.sv
// ----------------------------------------------------------------------------
// All-pairs shortest paths: channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface apsp_in_if import apsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [NODE_W-1:0]        from_node;
  logic [NODE_W-1:0]        to_node;
  logic signed [IN_W-1:0]   edge_weight_in;

  modport source (output valid, kind, from_node, to_node, edge_weight_in, input ready);
  modport sink   (input valid, kind, from_node, to_node, edge_weight_in, output ready);
endinterface

interface apsp_out_if import apsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind_echo;
  logic signed [OUT_W-1:0]  result_value;
  logic                     result_flag;
  logic                     accepted;

  modport source (output valid, kind_echo, result_value, result_flag, accepted, input ready);
  modport sink   (input valid, kind_echo, result_value, result_flag, accepted, output ready);
endinterface

FILE: rtl/apsp_ram.sv
// ----------------------------------------------------------------------------
// All-pairs shortest paths: generic RAM
// One write port, two read ports, registered read data held between reads.
// ----------------------------------------------------------------------------
module apsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: rtl/apsp_ctrl.sv
// ----------------------------------------------------------------------------
// All-pairs shortest paths: controller
// Sequences clearing, edge writes, reads and the Floyd-Warshall sweep.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_paths_macros.svh"

module apsp_ctrl import apsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_WIPE     = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_DECODE   = 12'b0000_0000_0100,
    S_CLEAR    = 12'b0000_0000_1000,
    S_MIRROR   = 12'b0000_0001_0000,
    S_INIT     = 12'b0000_0010_0000,
    S_INIT_END = 12'b0000_0100_0000,
    S_ROWK     = 12'b0000_1000_0000,
    S_LDIK     = 12'b0001_0000_0000,
    S_RELAX    = 12'b0010_0000_0000,
    S_NEXTROW  = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (st_i.wipe_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        case (st_i.kind)
          KIND_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_CLEAR;
          end
          KIND_ADD: begin
            if (st_i.in_range) begin
              cmd_o.add = 1'b1;
              if (!st_i.directed) state_d = S_MIRROR;
            end
          end
          KIND_COMPUTE: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_INIT;
          end
          KIND_DIST: cmd_o.rd_dist = st_i.in_range;
          KIND_EDGE: cmd_o.rd_edge = st_i.in_range;
          default:   state_d = S_RESP;
        endcase
      end
      S_CLEAR: begin
        cmd_o.wipe = 1'b1;
        if (st_i.wipe_last) state_d = S_RESP;
      end
      S_MIRROR: begin
        cmd_o.mirror = 1'b1;
        state_d      = S_RESP;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (st_i.b_last) begin
          cmd_o.row_next = 1'b1;
          if (st_i.a_last) state_d = S_INIT_END;
        end else begin
          cmd_o.step_j = 1'b1;
        end
      end
      S_INIT_END: begin
        cmd_o.cnt_clr = 1'b1;
        state_d       = S_ROWK;
      end
      S_ROWK: begin
        cmd_o.rd_ik = 1'b1;
        state_d     = S_LDIK;
      end
      S_LDIK: begin
        if (st_i.ik_reach) begin
          cmd_o.ld_ik = 1'b1;
          state_d     = S_RELAX;
        end else begin
          state_d = S_NEXTROW;
        end
      end
      S_RELAX: begin
        cmd_o.relax  = 1'b1;
        cmd_o.step_j = 1'b1;
        if (st_i.b_last) state_d = S_NEXTROW;
      end
      S_NEXTROW: begin
        cmd_o.row_next = 1'b1;
        state_d = (st_i.a_last && st_i.k_last) ? S_RESP : S_ROWK;
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_WIPE;
    endcase
  end

  `APSP_ASSERT(a_decode_after_idle, (state_q == S_DECODE) |-> ($past(state_q) == S_IDLE), "decode without an accepted item")
  `APSP_ASSERT_NEXT(a_row_end, (state_q == S_RELAX) && st_i.b_last, state_q == S_NEXTROW, "relax row did not end")
  `APSP_ASSERT_NEXT(a_resp_done, (state_q == S_RESP) && st_i.out_free, state_q == S_IDLE, "response not issued")

endmodule

FILE: rtl/apsp_dp.sv
// ----------------------------------------------------------------------------
// All-pairs shortest paths: datapath
// Edge and distance memories, counters, saturating relaxation, result register.
// ----------------------------------------------------------------------------
module apsp_dp import apsp_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  cmd_t                   cmd_i,
  output stat_t                  st_o,
  input  logic [KIND_W-1:0]      kind_i,
  input  logic [NODE_W-1:0]      from_node_i,
  input  logic [NODE_W-1:0]      to_node_i,
  input  logic signed [IN_W-1:0] edge_weight_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KIND_W-1:0]      kind_echo_o,
  output logic signed [OUT_W-1:0] result_value_o,
  output logic                   result_flag_o,
  output logic                   accepted_o
);

  localparam int NB    = $clog2(MAX_NODES);
  localparam int AW    = 2 * NB;
  localparam int DEPTH = 1 << AW;
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int CW    = (NCW > CNT_W) ? NCW : CNT_W;
  localparam int WB    = WEIGHT_BITS;
  localparam int EW    = (WB > OUT_W) ? WB : OUT_W;
  localparam int DW    = WB + 1;

  function automatic logic signed [WB-1:0] sat_in(logic signed [IN_W-1:0] x);
    logic signed [EW-1:0] xe, hi, lo;
    logic signed [WB-1:0] r;
    xe = EW'(x);
    hi = {{(EW-WB+1){1'b0}}, {(WB-1){1'b1}}};
    lo = ~hi;
    if (xe > hi) r = hi[WB-1:0];
    else if (xe < lo) r = lo[WB-1:0];
    else r = xe[WB-1:0];
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [WB-1:0] x);
    logic signed [EW-1:0] xe, hi, lo;
    logic signed [OUT_W-1:0] r;
    xe = EW'(x);
    hi = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = ~hi;
    if (xe > hi) r = hi[OUT_W-1:0];
    else if (xe < lo) r = lo[OUT_W-1:0];
    else r = xe[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [WB-1:0] sat_add(logic signed [WB-1:0] a,
                                                   logic signed [WB-1:0] b);
    logic signed [WB:0] s;
    logic signed [WB-1:0] r;
    s = (WB+1)'(a) + (WB+1)'(b);
    if (s[WB] != s[WB-1]) r = s[WB] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
    else r = s[WB-1:0];
    return r;
  endfunction

  // configuration
  logic [CNT_W-1:0] node_count_q;
  logic             directed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      directed_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        CFG_DIRECTED:   directed_q   <= cfg_data_i[0];
        default:        directed_q   <= directed_q;
      endcase
    end
  end

  logic [CW-1:0] nc, n_nodes, n_m1;
  always_comb begin
    nc = CW'(node_count_q);
    if (nc == '0) n_nodes = CW'(1);
    else if (nc > CW'(MAX_NODES)) n_nodes = CW'(MAX_NODES);
    else n_nodes = nc;
    n_m1 = n_nodes - CW'(1);
  end

  // held item
  logic [KIND_W-1:0]      kind_q;
  logic [NODE_W-1:0]      u_q, v_q;
  logic signed [IN_W-1:0] w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      u_q    <= from_node_i;
      v_q    <= to_node_i;
      w_q    <= edge_weight_in_i;
    end
  end

  logic          in_range;
  logic [NB-1:0] ui, vi;
  logic signed [WB-1:0] w_sat;
  assign in_range = (CW'(u_q) < n_nodes) && (CW'(v_q) < n_nodes);
  assign ui       = NB'(u_q);
  assign vi       = NB'(v_q);
  assign w_sat    = sat_in(w_q);

  // sweep counters: a = row i, b = column j, k = pivot
  logic [NB-1:0] a_q, b_q, k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      k_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      a_q <= '0;
      b_q <= '0;
      k_q <= '0;
    end else if (cmd_i.wipe) begin
      {a_q, b_q} <= {a_q, b_q} + AW'(1);
    end else if (cmd_i.row_next) begin
      b_q <= '0;
      if (CW'(a_q) == n_m1) begin
        a_q <= '0;
        k_q <= k_q + NB'(1);
      end else begin
        a_q <= a_q + NB'(1);
      end
    end else if (cmd_i.step_j) begin
      b_q <= b_q + NB'(1);
    end
  end

  // edge memory: {present, weight}
  logic          e_we, e_re;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [DW-1:0] e_wdata, e_rdata;

  always_comb begin
    e_we    = cmd_i.wipe | cmd_i.add | cmd_i.mirror;
    e_waddr = cmd_i.wipe ? {a_q, b_q} : (cmd_i.mirror ? {vi, ui} : {ui, vi});
    e_wdata = cmd_i.wipe ? '0 : {1'b1, w_sat};
    e_re    = cmd_i.rd_edge | cmd_i.init;
    e_raddr = cmd_i.rd_edge ? {ui, vi} : {a_q, b_q};
  end

  apsp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_edge_ram (
    .clk_i,
    .we_i      (e_we),
    .waddr_i   (e_waddr),
    .wdata_i   (e_wdata),
    .re_a_i    (e_re),
    .raddr_a_i (e_raddr),
    .rdata_a_o (e_rdata),
    .re_b_i    (1'b0),
    .raddr_b_i ('0),
    .rdata_b_o ()
  );

  // distance memory: {reachable, distance}
  logic          d_we, d_re_a, d_re_b;
  logic [AW-1:0] d_waddr, d_raddr_a, d_raddr_b;
  logic [DW-1:0] d_wdata, d_rdata_a, d_rdata_b;

  // init stage: write the seed distance in the cycle after the edge read
  logic          ini_v_q, ini_diag_q;
  logic [AW-1:0] ini_addr_q;
  // relax stage: compare and write in the cycle after the distance reads
  logic          rx_v_q, rx_jk_q;
  logic [AW-1:0] rx_addr_q;
  logic signed [WB-1:0] ik_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ini_v_q <= 1'b0;
      rx_v_q  <= 1'b0;
    end else begin
      ini_v_q <= cmd_i.init;
      rx_v_q  <= cmd_i.relax;
    end
  end

  always_ff @(posedge clk_i) begin
    ini_diag_q <= (a_q == b_q);
    ini_addr_q <= {a_q, b_q};
    rx_jk_q    <= (b_q == k_q);
    rx_addr_q  <= {a_q, b_q};
  end

  logic                 ij_reach, kj_reach, upd;
  logic signed [WB-1:0] ij_d, kj_d, alt;
  logic [DW-1:0]        seed;

  always_comb begin
    ij_reach = d_rdata_a[WB];
    ij_d     = d_rdata_a[WB-1:0];
    kj_reach = d_rdata_b[WB];
    kj_d     = d_rdata_b[WB-1:0];
    alt      = sat_add(ik_q, kj_d);
    upd      = rx_v_q && kj_reach && (!ij_reach || (alt < ij_d));
    if (ini_diag_q) seed = {1'b1, {WB{1'b0}}};
    else if (e_rdata[WB]) seed = e_rdata;
    else seed = '0;
    d_we      = ini_v_q | upd;
    d_waddr   = ini_v_q ? ini_addr_q : rx_addr_q;
    d_wdata   = ini_v_q ? seed : {1'b1, alt};
    d_re_a    = cmd_i.rd_dist | cmd_i.rd_ik | cmd_i.relax;
    d_raddr_a = cmd_i.rd_dist ? {ui, vi} : (cmd_i.rd_ik ? {a_q, k_q} : {a_q, b_q});
    d_re_b    = cmd_i.relax;
    d_raddr_b = {k_q, b_q};
  end

  // the row's pivot-column value d[i][k] is loaded by ld_ik and follows an update when the column reaches the pivot
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ik) begin
      ik_q <= d_rdata_a[WB-1:0];
    end else if (upd && rx_jk_q) begin
      ik_q <= alt;
    end
  end

  apsp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dist_ram (
    .clk_i,
    .we_i      (d_we),
    .waddr_i   (d_waddr),
    .wdata_i   (d_wdata),
    .re_a_i    (d_re_a),
    .raddr_a_i (d_raddr_a),
    .rdata_a_o (d_rdata_a),
    .re_b_i    (d_re_b),
    .raddr_b_i (d_raddr_b),
    .rdata_b_o (d_rdata_b)
  );

  // result register
  logic                    res_acc, res_flag;
  logic signed [OUT_W-1:0] res_val;

  always_comb begin
    res_acc  = 1'b0;
    res_flag = 1'b0;
    res_val  = '0;
    case (kind_q)
      KIND_CLEAR, KIND_COMPUTE: res_acc = 1'b1;
      KIND_ADD: res_acc = in_range;
      KIND_DIST: begin
        res_acc = in_range;
        if (in_range && d_rdata_a[WB]) begin
          res_flag = 1'b1;
          res_val  = sat_out(d_rdata_a[WB-1:0]);
        end
      end
      KIND_EDGE: begin
        res_acc = in_range;
        if (in_range) begin
          res_flag = e_rdata[WB];
          res_val  = sat_out(e_rdata[WB-1:0]);
        end
      end
      default: res_acc = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      kind_echo_o    <= kind_q;
      result_value_o <= res_val;
      result_flag_o  <= res_flag;
      accepted_o     <= res_acc;
    end
  end

  always_comb begin
    st_o.kind      = kind_q;
    st_o.in_range  = in_range;
    st_o.directed  = directed_q;
    st_o.wipe_last = &{a_q, b_q};
    st_o.a_last    = (CW'(a_q) == n_m1);
    st_o.b_last    = (CW'(b_q) == n_m1);
    st_o.k_last    = (CW'(k_q) == n_m1);
    st_o.ik_reach  = d_rdata_a[WB];
    st_o.out_free  = !out_valid_o || out_ready_i;
  end

endmodule

FILE: rtl/all_pairs_shortest_paths.sv
// ----------------------------------------------------------------------------
// All-pairs shortest paths: top level
// Edge matrix store with Floyd-Warshall over a distance memory.
// ----------------------------------------------------------------------------
// The block keeps a MAX_NODES x MAX_NODES matrix of edges (presence bit and
// signed Q16.16 weight saturated to WEIGHT_BITS) and a distance matrix of the
// same shape. Each input item returns exactly one result item. Clear wipes
// the edge memory one entry per cycle; the same pass runs after reset, and no
// item is taken until it ends. Add edge writes the edge, and a mirror entry
// too when undirected; reads go through a registered memory read. Compute
// seeds the distances, then for every pivot k and row i reads d[i][k] and,
// when reachable, relaxes the row at one column per cycle through a two-port
// distance memory. The result sits in an output register, so a finished
// result may wait on the sink without holding up the next item.
// ----------------------------------------------------------------------------
module all_pairs_shortest_paths import apsp_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  apsp_in_if.sink               in_i,
  apsp_out_if.source            out_o
);

  cmd_t  cmd;
  stat_t st;

  // sequence the item; the datapath only answers commands
  apsp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // memories, counters, relaxation and the result register
  apsp_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cmd_i            (cmd),
    .st_o             (st),
    .kind_i           (in_i.kind),
    .from_node_i      (in_i.from_node),
    .to_node_i        (in_i.to_node),
    .edge_weight_in_i (in_i.edge_weight_in),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .kind_echo_o      (out_o.kind_echo),
    .result_value_o   (out_o.result_value),
    .result_flag_o    (out_o.result_flag),
    .accepted_o       (out_o.accepted)
  );

endmodule
